@@ hdl/decimal_length_prefix_deframer_macros.svh @@
// Assertion macros for the decimal length-prefix deframer.
`ifndef DECIMAL_LENGTH_PREFIX_DEFRAMER_MACROS_SVH
`define DECIMAL_LENGTH_PREFIX_DEFRAMER_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every clock edge outside reset.
`define DLPD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("dlpd assertion failed");

// Check that a condition in one cycle implies another in the next cycle.
`define DLPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dlpd assertion failed");

`else

`define DLPD_ASSERT(lbl, clk, rst_n, prop)
`define DLPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ hdl/dlpd_pkg.sv @@
// Package with widths and constants of the decimal length-prefix deframer.
package dlpd_pkg;

  localparam int unsigned ByteW       = 8;
  localparam int unsigned HdrWidthW   = 4;
  localparam int unsigned LenW        = 27;
  localparam int unsigned MaxHdrDigits = 8;

  localparam logic [HdrWidthW-1:0] HdrWidthReset = HdrWidthW'(4);
  localparam logic [LenW-1:0]      MaxLenValue   = LenW'(99999999);

  localparam logic [ByteW-1:0] AsciiZero = 8'h30;
  localparam logic [ByteW-1:0] AsciiNine = 8'h39;
  localparam logic [ByteW-1:0] AsciiPad  = 8'h2A;

  typedef logic [ByteW-1:0]     byte_t;
  typedef logic [HdrWidthW-1:0] hdr_width_t;
  typedef logic [LenW-1:0]      len_t;

endpackage

@@ hdl/dlpd_if.sv @@
// Handshake channel interfaces of the decimal length-prefix deframer.
interface dlpd_in_if
  import dlpd_pkg::*;
();
  logic  valid;
  logic  ready;
  byte_t data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface dlpd_out_if
  import dlpd_pkg::*;
();
  logic  valid;
  logic  ready;
  byte_t payload_byte;
  logic  is_last;
  logic  is_empty;

  modport source (output valid, output payload_byte, output is_last, output is_empty,
                  input ready);
  modport sink   (input valid, input payload_byte, input is_last, input is_empty,
                  output ready);
endinterface

interface dlpd_cfg_if
  import dlpd_pkg::*;
();
  logic       valid;
  logic       ready;
  hdr_width_t header_width;

  modport source (output valid, output header_width, input ready);
  modport sink   (input valid, input header_width, output ready);
endinterface

@@ hdl/decimal_length_prefix_deframer.sv @@
// Path from input transaction to result: input register, then result register.
// Throughput: one byte per cycle while results drain; a stalled result holds every byte.
// The input stage advances whenever the result register is empty or being drained.
// Reset: header phase, header width 4, no byte held, no result pending.
`include "decimal_length_prefix_deframer_macros.svh"

module decimal_length_prefix_deframer
  import dlpd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  dlpd_cfg_if.sink    cfg_i,
  dlpd_in_if.sink     in_i,
  dlpd_out_if.source  out_o
);

  // configuration
  hdr_width_t hdr_width_q;

  // input register
  logic  s1_valid_q;
  byte_t s1_byte_q;
  logic  s1_adv;

  // frame state
  logic                 in_payload_q, in_payload_d;
  logic [HdrWidthW-1:0] hdr_idx_q, hdr_idx_d;
  logic                 digits_ended_q, digits_ended_d;
  len_t                 len_q, len_d;
  len_t                 rem_q, rem_d;

  // result register
  logic  out_valid_q;
  byte_t out_byte_q;
  logic  out_last_q;
  logic  out_empty_q;

  // per-byte result
  logic  res_valid;
  byte_t res_byte;
  logic  res_last;
  logic  res_empty;

  logic                 is_digit;
  logic                 hdr_end;
  hdr_width_t           eff_width;
  len_t                 len_acc;
  logic [LenW+2:0]      len_mul;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_width_q <= HdrWidthReset;
    end else if (cfg_i.valid) begin
      hdr_width_q <= cfg_i.header_width;
    end
  end

  // Advance the input stage when the result register can take a new value.
  assign s1_adv     = !out_valid_q || out_o.ready;
  assign in_i.ready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_byte_q <= in_i.data_byte;
    end
  end

  assign eff_width = (hdr_width_q == '0) ? HdrWidthW'(1) : hdr_width_q;
  assign is_digit  = (s1_byte_q >= AsciiZero) && (s1_byte_q <= AsciiNine);
  assign hdr_end   = ({1'b0, hdr_idx_q} + (HdrWidthW+1)'(1)) >= {1'b0, eff_width};
  // len * 10 as (len << 3) + (len << 1), plus the digit value
  assign len_mul   = {len_q, 3'b000} + {2'b00, len_q, 1'b0}
                   + (LenW+3)'(s1_byte_q - AsciiZero);

  always_comb begin
    in_payload_d   = in_payload_q;
    hdr_idx_d      = hdr_idx_q;
    digits_ended_d = digits_ended_q;
    len_d          = len_q;
    rem_d          = rem_q;
    res_valid      = 1'b0;
    res_byte       = s1_byte_q;
    res_last       = 1'b0;
    res_empty      = 1'b0;
    len_acc        = len_q;

    if (in_payload_q) begin
      rem_d     = rem_q - LenW'(1);
      res_valid = 1'b1;
      res_last  = (rem_d == '0);
      if (rem_d == '0) begin
        in_payload_d = 1'b0;
      end
    end else begin
      if (!digits_ended_q) begin
        if (is_digit && (hdr_idx_q < HdrWidthW'(MaxHdrDigits))) begin
          len_acc = len_mul[LenW-1:0];
        end else begin
          digits_ended_d = 1'b1;
        end
      end
      len_d = len_acc;
      if (hdr_end) begin
        hdr_idx_d      = '0;
        digits_ended_d = 1'b0;
        len_d          = '0;
        if (len_acc == '0) begin
          res_valid = 1'b1;
          res_byte  = '0;
          res_last  = 1'b1;
          res_empty = 1'b1;
        end else begin
          rem_d        = len_acc;
          in_payload_d = 1'b1;
        end
      end else begin
        hdr_idx_d = hdr_idx_q + HdrWidthW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_payload_q   <= 1'b0;
      hdr_idx_q      <= '0;
      digits_ended_q <= 1'b0;
      len_q          <= '0;
      rem_q          <= '0;
    end else if (s1_valid_q && s1_adv) begin
      in_payload_q   <= in_payload_d;
      hdr_idx_q      <= hdr_idx_d;
      digits_ended_q <= digits_ended_d;
      len_q          <= len_d;
      rem_q          <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_valid_q && s1_adv && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Hold the payload until the result transaction completes.
  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s1_adv && res_valid) begin
      out_byte_q  <= res_byte;
      out_last_q  <= res_last;
      out_empty_q <= res_empty;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.payload_byte = out_byte_q;
  assign out_o.is_last      = out_last_q;
  assign out_o.is_empty     = out_empty_q;

  `DLPD_ASSERT(a_payload_has_bytes, clk_i, rst_ni, !in_payload_q || (rem_q != '0))
  `DLPD_ASSERT(a_len_digit_bound, clk_i, rst_ni, len_q <= MaxLenValue)
  `DLPD_ASSERT(a_empty_is_last, clk_i, rst_ni,
               !(out_valid_q && out_empty_q) || (out_last_q && (out_byte_q == '0)))
  `DLPD_ASSERT_NEXT(a_payload_gives_result, clk_i, rst_ni,
                    s1_valid_q && s1_adv && in_payload_q, out_valid_q)
  `DLPD_ASSERT_NEXT(a_header_clears_len, clk_i, rst_ni,
                    s1_valid_q && s1_adv && !in_payload_q && hdr_end,
                    (len_q == '0) && (hdr_idx_q == '0) && !digits_ended_q)

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the decimal length-prefix deframer.
module testbench;
  import dlpd_pkg::*;

  localparam int unsigned CycleLimit   = 300000;
  localparam int unsigned ReportLimit  = 10;
  localparam int unsigned PhaseItems   = 55;
  localparam int unsigned SettleCycles = 4;

  typedef struct packed {
    byte_t payload_byte;
    logic  is_last;
    logic  is_empty;
  } frame_out_t;

  function automatic bit is_digit(byte_t b);
    return b >= AsciiZero && b <= AsciiNine;
  endfunction

  // Tracks the frame state of the stream and holds the payload results still owed.
  class deframer_tracker;
    frame_out_t  expected_payload[$];
    hdr_width_t  hdr_width;
    logic        in_payload;
    logic [3:0]  hdr_idx;
    logic        digits_done;
    len_t        len_acc;
    len_t        remaining;
    int unsigned errors;

    function new();
      hdr_width   = HdrWidthReset;
      in_payload  = 1'b0;
      hdr_idx     = '0;
      digits_done = 1'b0;
      len_acc     = '0;
      remaining   = '0;
      errors      = 0;
    endfunction

    function void set_width(hdr_width_t w);
      hdr_width = w;
    endfunction

    function void accept_byte(byte_t b);
      frame_out_t  res;
      int unsigned eff;
      if (in_payload) begin
        remaining        = remaining - 1'b1;
        res.payload_byte = b;
        res.is_last      = (remaining == '0);
        res.is_empty     = 1'b0;
        expected_payload.insert(expected_payload.size(), res);
        if (remaining == '0) in_payload = 1'b0;
        return;
      end
      if (!digits_done) begin
        if (is_digit(b) && hdr_idx < MaxHdrDigits) begin
          len_acc = len_t'(len_acc * 10 + (b - AsciiZero));
        end else begin
          digits_done = 1'b1;
        end
      end
      eff = (hdr_width == '0) ? 1 : hdr_width;
      if (hdr_idx + 1 >= eff) begin
        hdr_idx     = '0;
        digits_done = 1'b0;
        if (len_acc == '0) begin
          res.payload_byte = '0;
          res.is_last      = 1'b1;
          res.is_empty     = 1'b1;
          expected_payload.insert(expected_payload.size(), res);
        end else begin
          remaining  = len_acc;
          in_payload = 1'b1;
        end
        len_acc = '0;
      end else begin
        hdr_idx = hdr_idx + 1'b1;
      end
    endfunction

    function void check_result(byte_t pb, logic lst, logic emp);
      frame_out_t exp_r;
      if (expected_payload.size() == 0) begin
        errors++;
        if (errors <= ReportLimit)
          $display("unexpected result: byte %02h last %0b empty %0b", pb, lst, emp);
        return;
      end
      exp_r = expected_payload.pop_front();
      if (exp_r.payload_byte !== pb || exp_r.is_last !== lst || exp_r.is_empty !== emp) begin
        errors++;
        if (errors <= ReportLimit)
          $display("mismatch: expected byte %02h last %0b empty %0b, got byte %02h last %0b empty %0b",
                   exp_r.payload_byte, exp_r.is_last, exp_r.is_empty, pb, lst, emp);
      end
    endfunction

    function void check_drained();
      if (expected_payload.size() != 0) begin
        errors++;
        $display("%0d results never arrived", expected_payload.size());
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  bit          calm;
  int unsigned cycles;
  int unsigned sent_count;
  deframer_tracker tracker;

  hdr_width_t phase_widths [16] = '{4'd8, 4'd1, 4'd15, 4'd0, 4'd9, 4'd2, 4'd12, 4'd5,
                                    4'd3, 4'd7, 4'd6, 4'd4, 4'd10, 4'd11, 4'd13, 4'd14};

  dlpd_cfg_if cfg_if ();
  dlpd_in_if  in_if ();
  dlpd_out_if out_if ();

  decimal_length_prefix_deframer u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // Check each result transaction and stall the output at random.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready)
      tracker.check_result(out_if.payload_byte, out_if.is_last, out_if.is_empty);
    out_if.ready <= calm || ($urandom_range(0, 99) >= 13);
  end

  task automatic send_byte(input byte_t b);
    while (!calm && $urandom_range(0, 99) < 13) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.data_byte <= b;
    do @(posedge clk_i); while (!in_if.ready);
    tracker.accept_byte(b);
    sent_count++;
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(byte_t'(s[i]));
  endtask

  // Hold the input low until every result is out, then let the pipeline settle.
  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (tracker.expected_payload.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_width(input hdr_width_t w);
    drain_results();
    cfg_if.valid        <= 1'b1;
    cfg_if.header_width <= w;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    tracker.set_width(w);
  endtask

  task automatic send_frame(input hdr_width_t w);
    int unsigned eff, cap, len, lim, r, pos, n;
    string       digs;
    byte_t       b;
    eff = (w == '0) ? 1 : w;
    cap = (eff > MaxHdrDigits) ? MaxHdrDigits : eff;
    if ($urandom_range(0, 99) < 15) begin
      // noise header; digits only in the first three bytes keep the length short
      for (pos = 0; pos < eff; pos++) begin
        b = byte_t'($urandom_range(0, 255));
        if (pos >= 3 && is_digit(b)) b = AsciiPad;
        send_byte(b);
      end
    end else begin
      r = $urandom_range(0, 99);
      if (r < 65) len = $urandom_range(0, 15);
      else if (r < 93) len = $urandom_range(16, 100);
      else len = $urandom_range(101, 300);
      lim = 1;
      repeat (cap) lim = lim * 10;
      len = len % lim;
      digs = (len == 0 && $urandom_range(0, 1) == 0) ? "" : $sformatf("%0d", len);
      if (eff > MaxHdrDigits && $urandom_range(0, 2) == 0) begin
        // fill every digit position so the digits past the limit are dropped
        while (digs.len() < cap) digs = {"0", digs};
        while (digs.len() < eff) digs = {digs, $sformatf("%0d", $urandom_range(0, 9))};
      end else begin
        n = $urandom_range(0, cap - digs.len());
        repeat (n) digs = {"0", digs};
      end
      for (pos = 0; pos < eff; pos++) begin
        if (pos < digs.len()) begin
          b = byte_t'(digs[pos]);
        end else if ($urandom_range(0, 4) != 0) begin
          b = AsciiPad;
        end else begin
          do b = byte_t'($urandom_range(0, 255)); while (is_digit(b));
        end
        send_byte(b);
      end
    end
    n = tracker.in_payload ? tracker.remaining : 0;
    // cut a long payload short; the next header is then taken in whole as payload
    if (n > 15 && $urandom_range(0, 19) == 0) n = n - $urandom_range(15, n - 1);
    repeat (n) send_byte(byte_t'($urandom_range(0, 255)));
  endtask

  initial begin
    int          ph;
    int unsigned phase_end;
    tracker             = new();
    clk_i               = 1'b0;
    rst_ni              = 1'b0;
    calm                = 1'b0;
    cycles              = 0;
    sent_count          = 0;
    in_if.valid         = 1'b0;
    in_if.data_byte     = '0;
    cfg_if.valid        = 1'b0;
    cfg_if.header_width = HdrWidthReset;
    out_if.ready        = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // width of four from reset
    send_text("3***");
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_text("****");          // leading pad gives an empty frame
    send_text("1x9*");          // digits stop at the first non-digit
    send_byte(8'hA5);
    write_width(4'd1);
    send_text("0");
    send_text("*");
    write_width(4'd0);          // width zero acts as one
    send_text("2");
    send_byte(8'h11);
    send_byte(8'h22);
    write_width(4'd4);
    send_text("1*");
    write_width(4'd2);          // shrink the width in the middle of a header
    send_text("*");
    send_byte(8'h7E);

    for (ph = 0; ph < 16; ph++) begin
      write_width(phase_widths[ph]);
      calm = (ph >= 6 && ph < 9);
      phase_end = sent_count + PhaseItems;
      while (sent_count < phase_end) send_frame(phase_widths[ph]);
    end
    calm = 1'b0;

    drain_results();
    repeat (10) @(posedge clk_i);
    tracker.check_drained();
    if (tracker.errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

@@ decimal_length_prefix_deframer.f @@
+incdir+hdl
hdl/dlpd_pkg.sv
hdl/dlpd_if.sv
hdl/decimal_length_prefix_deframer.sv
tb/testbench.sv
